// ===== rtl/core/sshc_pkg.sv =====
// Shared types, constants and helpers for the sleep state hysteresis classifier.
// No dependencies.
package sshc_pkg;

  localparam int unsigned ThrW    = 16;
  localparam int unsigned CntW    = 8;
  localparam int unsigned FracW   = 9;
  localparam int unsigned PctW    = 7;
  localparam int unsigned StateW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PctW-1:0]  OobPctLimit = 7'd20;
  localparam logic [FracW-1:0] MicGate     = 9'd64;
  localparam logic [CntW-1:0]  CntMax      = 8'd255;
  localparam logic [CntW-1:0]  StirSettle  = 8'd2;
  localparam logic [CntW-1:0]  AwakeSettle = 8'd3;

  // floor(x / 5) for x below 2^18: x * ceil(2^20 / 5) >> 20
  localparam int unsigned    OffShift = 20;
  localparam logic [17:0]    OffRecip = 18'((2 ** OffShift + 4) / 5);

  localparam logic [ThrW-1:0] AwakeThrRst   = 16'd300;
  localparam logic [ThrW-1:0] StirThrRst    = 16'd100;
  localparam logic [CntW-1:0] AwakeConfRst  = 8'd2;
  localparam logic [CntW-1:0] OobConfRst    = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AWAKE_THR  = 2'd0,
    CFG_STIR_THR   = 2'd1,
    CFG_AWAKE_CONF = 2'd2,
    CFG_OOB_CONF   = 2'd3
  } cfg_idx_e;

  typedef enum logic [StateW-1:0] {
    SS_UNKNOWN  = 2'd0,
    SS_ASLEEP   = 2'd1,
    SS_STIRRING = 2'd2,
    SS_AWAKE    = 2'd3
  } sleep_code_e;

  typedef enum logic [3:0] {
    PH_UNKNOWN  = 4'b0001,
    PH_ASLEEP   = 4'b0010,
    PH_STIRRING = 4'b0100,
    PH_AWAKE    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ThrW-1:0] awake_thr;
    logic [ThrW-1:0] awake_off;
    logic [ThrW-1:0] stir_thr;
    logic [ThrW-1:0] stir_off;
    logic [CntW-1:0] awake_conf;
    logic [CntW-1:0] oob_conf;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0] sleep_state;
    logic              state_changed;
    logic [CntW-1:0]   out_of_bed_run;
  } res_t;

  function automatic logic [ThrW-1:0] off_level(input logic [ThrW-1:0] thr);
    logic [17:0] x;
    logic [35:0] p;
    x = {1'b0, thr, 1'b0} + {2'b00, thr};
    p = 36'(x) * 36'(OffRecip);
    return p[OffShift +: ThrW];
  endfunction

  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + 8'd1;
  endfunction

  function automatic logic [StateW-1:0] phase_code(input phase_e ph);
    logic [StateW-1:0] c;
    unique case (ph)
      PH_UNKNOWN:  c = SS_UNKNOWN;
      PH_ASLEEP:   c = SS_ASLEEP;
      PH_STIRRING: c = SS_STIRRING;
      PH_AWAKE:    c = SS_AWAKE;
      default:     c = SS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/sshc_cfg.sv =====
// Configuration register file with precomputed off-levels.
// Depends on sshc_pkg.
module sshc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sshc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sshc_pkg::ThrW-1:0]     cfg_wdata_i,
  output sshc_pkg::cfg_t                cfg_o
);

  sshc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.awake_thr  <= sshc_pkg::AwakeThrRst;
      cfg_q.awake_off  <= sshc_pkg::off_level(sshc_pkg::AwakeThrRst);
      cfg_q.stir_thr   <= sshc_pkg::StirThrRst;
      cfg_q.stir_off   <= sshc_pkg::off_level(sshc_pkg::StirThrRst);
      cfg_q.awake_conf <= sshc_pkg::AwakeConfRst;
      cfg_q.oob_conf   <= sshc_pkg::OobConfRst;
    end else if (cfg_we_i) begin
      unique case (sshc_pkg::cfg_idx_e'(cfg_idx_i))
        sshc_pkg::CFG_AWAKE_THR: begin
          cfg_q.awake_thr <= cfg_wdata_i;
          cfg_q.awake_off <= sshc_pkg::off_level(cfg_wdata_i);
        end
        sshc_pkg::CFG_STIR_THR: begin
          cfg_q.stir_thr <= cfg_wdata_i;
          cfg_q.stir_off <= sshc_pkg::off_level(cfg_wdata_i);
        end
        sshc_pkg::CFG_AWAKE_CONF: cfg_q.awake_conf <= cfg_wdata_i[sshc_pkg::CntW-1:0];
        sshc_pkg::CFG_OOB_CONF:   cfg_q.oob_conf   <= cfg_wdata_i[sshc_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/sshc_fsm.sv =====
// Run counters, out-of-bed count and the four-state hysteresis machine.
// Depends on sshc_pkg.
module sshc_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  logic [sshc_pkg::ThrW-1:0]  act_i,
  input  logic [sshc_pkg::PctW-1:0]  bed_i,
  input  sshc_pkg::cfg_t             cfg_i,
  output sshc_pkg::res_t             res_o
);

  sshc_pkg::phase_e phase_q, phase_d, phase_nx;
  logic [sshc_pkg::CntW-1:0] aa_q, aa_d, ba_q, ba_d, as_q, as_d, bs_q, bs_d;
  logic [sshc_pkg::CntW-1:0] aa_t, ba_t, as_t, bs_t;
  logic [sshc_pkg::CntW-1:0] oob_q, oob_d;
  logic                      chg;

  always_comb begin
    oob_d = (bed_i < sshc_pkg::OobPctLimit) ? sshc_pkg::inc_sat(oob_q) : '0;

    aa_t = aa_q;
    ba_t = ba_q;
    if (act_i > cfg_i.awake_thr) begin
      aa_t = sshc_pkg::inc_sat(aa_q);
      ba_t = '0;
    end else if (act_i < cfg_i.awake_off) begin
      ba_t = sshc_pkg::inc_sat(ba_q);
      aa_t = '0;
    end

    as_t = as_q;
    bs_t = bs_q;
    if (act_i > cfg_i.stir_thr) begin
      as_t = sshc_pkg::inc_sat(as_q);
      bs_t = '0;
    end else if (act_i < cfg_i.stir_off) begin
      bs_t = sshc_pkg::inc_sat(bs_q);
      as_t = '0;
    end

    phase_nx = phase_q;
    unique case (phase_q)
      sshc_pkg::PH_UNKNOWN: begin
        phase_nx = (act_i > cfg_i.stir_thr) ? sshc_pkg::PH_STIRRING : sshc_pkg::PH_ASLEEP;
      end
      sshc_pkg::PH_ASLEEP: begin
        if (aa_t >= cfg_i.awake_conf) phase_nx = sshc_pkg::PH_AWAKE;
        else if (as_t != '0)          phase_nx = sshc_pkg::PH_STIRRING;
      end
      sshc_pkg::PH_STIRRING: begin
        if (aa_t >= cfg_i.awake_conf)         phase_nx = sshc_pkg::PH_AWAKE;
        else if (bs_t >= sshc_pkg::StirSettle) phase_nx = sshc_pkg::PH_ASLEEP;
      end
      sshc_pkg::PH_AWAKE: begin
        if (ba_t >= sshc_pkg::AwakeSettle) phase_nx = sshc_pkg::PH_STIRRING;
      end
      default: phase_nx = sshc_pkg::PH_UNKNOWN;
    endcase

    if (oob_d >= cfg_i.oob_conf) phase_nx = sshc_pkg::PH_AWAKE;

    chg     = (phase_nx != phase_q);
    phase_d = phase_nx;
    aa_d    = chg ? '0 : aa_t;
    ba_d    = chg ? '0 : ba_t;
    as_d    = chg ? '0 : as_t;
    bs_d    = chg ? '0 : bs_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sshc_pkg::PH_UNKNOWN;
      aa_q    <= '0;
      ba_q    <= '0;
      as_q    <= '0;
      bs_q    <= '0;
      oob_q   <= '0;
    end else if (upd_i) begin
      phase_q <= phase_d;
      aa_q    <= aa_d;
      ba_q    <= ba_d;
      as_q    <= as_d;
      bs_q    <= bs_d;
      oob_q   <= oob_d;
    end
  end

  assign res_o.sleep_state    = sshc_pkg::phase_code(phase_d);
  assign res_o.state_changed  = chg;
  assign res_o.out_of_bed_run = oob_d;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register lost one-hot encoding");

  a_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && chg |=> aa_q == '0 && ba_q == '0 && as_q == '0 && bs_q == '0)
    else $error("run counters not cleared on state change");

  a_oob_forces_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (oob_d >= cfg_i.oob_conf) |=> phase_q == sshc_pkg::PH_AWAKE)
    else $error("sustained out-of-bed run did not force awake");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(phase_q) && $stable(oob_q))
    else $error("state moved without a transfer");

endmodule

// ===== rtl/core/sleep_state_hysteresis_classifier.sv =====
// Sleep state hysteresis classifier top level: input register, mic boost, result register.
// Depends on sshc_pkg, sshc_cfg and sshc_fsm.
//
// One epoch is accepted per clock cycle while out_ready_i is high; each result passes from
// its epoch transfer through the input register and then the result register, which loads
// it once the output slot is free. While a finished result waits on out_ready_i, the input
// register takes at most one more epoch and then holds in_ready_o low. The cycle time is set
// by the path from the input register through the 16x9 mic boost multiply, the saturating
// add and the threshold compares into the state and result registers. Configuration writes
// take effect at the next clock edge; write them only while the block holds no epoch.
module sleep_state_hysteresis_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sshc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sshc_pkg::ThrW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sshc_pkg::ThrW-1:0]     activity_counts_i,
  input  logic [sshc_pkg::FracW-1:0]    mic_loud_fraction_i,
  input  logic [sshc_pkg::PctW-1:0]     in_bed_percent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sshc_pkg::StateW-1:0]   sleep_state_o,
  output logic                          state_changed_o,
  output logic [sshc_pkg::CntW-1:0]     out_of_bed_run_o
);

  sshc_pkg::cfg_t cfg;
  sshc_pkg::res_t res, res_q;

  logic                         s1_valid_q, out_valid_q, fire;
  logic [sshc_pkg::ThrW-1:0]    act_q;
  logic [sshc_pkg::FracW-1:0]   frac_q;
  logic [sshc_pkg::PctW-1:0]    bed_q;
  logic [24:0]                  prod;
  logic [17:0]                  sum;
  logic [sshc_pkg::ThrW-1:0]    eff;

  sshc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= activity_counts_i;
      frac_q <= mic_loud_fraction_i;
      bed_q  <= in_bed_percent_i;
    end
    if (fire) res_q <= res;
  end

  // boost activity by floor(stir_thr * frac / 256) when the mic was loud, saturate at max
  always_comb begin
    prod = 25'(cfg.stir_thr) * 25'(frac_q);
    sum  = {2'b00, act_q} + ((frac_q > sshc_pkg::MicGate) ? {1'b0, prod[24:8]} : 18'd0);
    eff  = (sum[17:16] != 2'b00) ? '1 : sum[sshc_pkg::ThrW-1:0];
  end

  sshc_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire),
    .act_i  (eff),
    .bed_i  (bed_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign sleep_state_o    = res_q.sleep_state;
  assign state_changed_o  = res_q.state_changed;
  assign out_of_bed_run_o = res_q.out_of_bed_run;

endmodule
